// ----- hw/rtl/tai_pkg.sv -----
package tai_pkg;

  // arena geometry
  localparam int unsigned ARENA_BYTES = 65536;
  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned ALIGN       = 16;
  localparam int unsigned ALIGN_SHIFT = $clog2(ALIGN);

  // field widths
  localparam int unsigned IDX_W   = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned OFF_W   = 17;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned VER_W   = 32;
  localparam int unsigned UNITS_W = 13;
  localparam int unsigned PAD_W   = 4;

  // low nibble of an entry's pad byte holds the padding
  localparam logic [7:0] PAD_BITS = 8'h0F;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_NEXT  = 2'd1,
    OP_POP   = 2'd2,
    OP_CHECK = 2'd3
  } tai_op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_END     = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_INVALID = 3'd4
  } tai_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_SCAN,
    S_EVAL,
    S_OUT
  } tai_state_t;

  // one entry of the index table
  typedef struct packed {
    logic [UNITS_W-1:0] units;
    logic [PAD_W-1:0]   pad;
    logic               deleted;
  } tai_entry_t;

endpackage

// ----- hw/rtl/tai_ram.sv -----
module tai_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/tombstone_arena_index.sv -----
// Bookkeeping for a bump-pointer arena with tombstoned entries; no payload bytes are held.
// One item is worked on at a time and in_stall stays high until its result transfer is taken.
// Alloc passes S_ALLOC alone, pop of an empty arena goes straight to S_OUT, and check and pop by
// cursor pass S_SCAN and S_EVAL, or S_SCAN alone when the index is past the written entries.
// Iterate and pop of the first live entry pass S_SCAN and S_EVAL once per entry examined, and
// iterate passes S_SCAN once more when it runs past the last entry; every entry is read through
// the single registered read port of the entry table. A stalled output holds the result in S_OUT.
// The entry table needs no clearing after reset: only entries below the written count are ever
// read.
module tombstone_arena_index (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [16:0] in_req_len,
  input  logic        in_use_first,
  input  logic [10:0] in_cursor_index,
  input  logic [16:0] in_cursor_offset,
  input  logic [10:0] in_next_index,
  input  logic [16:0] in_next_offset,
  input  logic [31:0] in_cursor_version,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [16:0] out_item_offset,
  output logic [10:0] out_entry_number,
  output logic [16:0] out_item_length,
  output logic [10:0] out_new_next_index,
  output logic [16:0] out_new_next_offset,
  output logic [31:0] out_version_out,
  output logic [10:0] out_live_items,
  output logic [16:0] out_bytes_used,
  output logic        out_valid_res
);

  localparam int unsigned ENTRY_W = $bits(tai_pkg::tai_entry_t);

  tai_pkg::tai_state_t  state_r, state_nxt;
  tai_pkg::tai_op_t     op_r, op_nxt;
  tai_pkg::tai_status_t status_r, status_nxt;

  logic [tai_pkg::LEN_W-1:0] dlen_r, dlen_nxt;
  logic                      first_r, first_nxt;
  logic [tai_pkg::OFF_W-1:0] coff_r, coff_nxt;
  logic [tai_pkg::VER_W-1:0] cver_r, cver_nxt;
  logic [tai_pkg::CNT_W-1:0] i_r, i_nxt;
  logic [tai_pkg::OFF_W-1:0] off_r, off_nxt;
  logic [tai_pkg::VER_W-1:0] vout_r, vout_nxt;
  logic [tai_pkg::OFF_W-1:0] ioff_r, ioff_nxt;
  logic [tai_pkg::CNT_W-1:0] enr_r, enr_nxt;
  logic [tai_pkg::LEN_W-1:0] ilen_r, ilen_nxt;
  logic                      valid_r, valid_nxt;

  logic [tai_pkg::OFF_W-1:0] wp_r, wp_nxt;
  logic [tai_pkg::CNT_W-1:0] ew_r, ew_nxt;
  logic [tai_pkg::CNT_W-1:0] live_r, live_nxt;
  logic [tai_pkg::VER_W-1:0] ver_r, ver_nxt;

  // entry table port
  logic                      ram_we, ram_re;
  logic [tai_pkg::IDX_W-1:0] ram_waddr, ram_raddr;
  tai_pkg::tai_entry_t       ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0]        ram_rdata_raw;

  // alloc arithmetic
  logic [tai_pkg::LEN_W:0]    dlen_up;
  logic [tai_pkg::LEN_W-tai_pkg::ALIGN_SHIFT:0] units_w;
  logic [tai_pkg::LEN_W:0]    aligned_w;
  logic [tai_pkg::LEN_W+1:0]  end_w;
  logic                       alloc_full;

  // entry walk arithmetic
  logic [tai_pkg::OFF_W-1:0] size_w, next_off_w;
  logic [tai_pkg::LEN_W-1:0] len_w;

  tai_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (tai_pkg::MAX_ENTRIES)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata_raw)
  );

  assign ram_rdata = tai_pkg::tai_entry_t'(ram_rdata_raw);

  // round the requested length up to the alignment
  assign dlen_up    = {1'b0, dlen_r} + (tai_pkg::LEN_W+1)'(tai_pkg::ALIGN - 1);
  assign units_w    = dlen_up[tai_pkg::LEN_W:tai_pkg::ALIGN_SHIFT];
  assign aligned_w  = {units_w, {tai_pkg::ALIGN_SHIFT{1'b0}}};
  assign end_w      = {2'b00, wp_r} + {1'b0, aligned_w};
  assign alloc_full = (ew_r >= tai_pkg::CNT_W'(tai_pkg::MAX_ENTRIES)) ||
                      (end_w > (tai_pkg::LEN_W+2)'(tai_pkg::ARENA_BYTES));

  // size, end and true length of the entry just read
  assign size_w     = tai_pkg::OFF_W'({ram_rdata.units, {tai_pkg::ALIGN_SHIFT{1'b0}}});
  assign next_off_w = off_r + size_w;
  assign len_w      = size_w -
                      tai_pkg::LEN_W'(ram_rdata.pad & tai_pkg::PAD_BITS[tai_pkg::PAD_W-1:0]);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tai_pkg::S_IDLE;
      wp_r    <= '0;
      ew_r    <= '0;
      live_r  <= '0;
      ver_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      ew_r    <= ew_nxt;
      live_r  <= live_nxt;
      ver_r   <= ver_nxt;
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    status_r <= status_nxt;
    dlen_r   <= dlen_nxt;
    first_r  <= first_nxt;
    coff_r   <= coff_nxt;
    cver_r   <= cver_nxt;
    i_r      <= i_nxt;
    off_r    <= off_nxt;
    vout_r   <= vout_nxt;
    ioff_r   <= ioff_nxt;
    enr_r    <= enr_nxt;
    ilen_r   <= ilen_nxt;
    valid_r  <= valid_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    dlen_nxt   = dlen_r;
    first_nxt  = first_r;
    coff_nxt   = coff_r;
    cver_nxt   = cver_r;
    i_nxt      = i_r;
    off_nxt    = off_r;
    vout_nxt   = vout_r;
    ioff_nxt   = ioff_r;
    enr_nxt    = enr_r;
    ilen_nxt   = ilen_r;
    valid_nxt  = valid_r;
    wp_nxt     = wp_r;
    ew_nxt     = ew_r;
    live_nxt   = live_r;
    ver_nxt    = ver_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = i_r[tai_pkg::IDX_W-1:0];
    ram_waddr  = i_r[tai_pkg::IDX_W-1:0];
    ram_wdata  = ram_rdata;

    unique case (state_r)
      tai_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt     = tai_pkg::tai_op_t'(in_opcode);
          status_nxt = tai_pkg::ST_OK;
          dlen_nxt   = in_req_len;
          first_nxt  = in_use_first;
          coff_nxt   = in_cursor_offset;
          cver_nxt   = in_cursor_version;
          i_nxt      = in_next_index;
          off_nxt    = in_next_offset;
          vout_nxt   = (in_cursor_index == '0 && in_next_offset == '0) ?
                       ver_r : in_cursor_version;
          ioff_nxt   = '0;
          enr_nxt    = '0;
          ilen_nxt   = '0;
          valid_nxt  = 1'b0;
          unique case (tai_pkg::tai_op_t'(in_opcode))
            tai_pkg::OP_ALLOC: state_nxt = tai_pkg::S_ALLOC;
            tai_pkg::OP_NEXT:  state_nxt = tai_pkg::S_SCAN;
            tai_pkg::OP_POP: begin
              if (live_r == '0) begin
                status_nxt = tai_pkg::ST_EMPTY;
                state_nxt  = tai_pkg::S_OUT;
              end else begin
                i_nxt     = in_use_first ? '0 : in_cursor_index;
                state_nxt = tai_pkg::S_SCAN;
              end
            end
            tai_pkg::OP_CHECK: begin
              i_nxt     = in_cursor_index;
              state_nxt = tai_pkg::S_SCAN;
            end
          endcase
        end
      end

      // append one entry at the write position, or report a full arena
      tai_pkg::S_ALLOC: begin
        if (alloc_full) begin
          status_nxt = tai_pkg::ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ew_r[tai_pkg::IDX_W-1:0];
          ram_wdata.units   = units_w[tai_pkg::UNITS_W-1:0];
          ram_wdata.pad     = tai_pkg::PAD_W'(0) - dlen_r[tai_pkg::PAD_W-1:0];
          ram_wdata.deleted = 1'b0;
          ioff_nxt  = wp_r;
          enr_nxt   = ew_r;
          wp_nxt    = end_w[tai_pkg::OFF_W-1:0];
          ew_nxt    = ew_r + 1'b1;
          live_nxt  = live_r + 1'b1;
        end
        state_nxt = tai_pkg::S_OUT;
      end

      // bounds check and table read for the current entry
      tai_pkg::S_SCAN: begin
        if (i_r >= ew_r) begin
          status_nxt = (op_r == tai_pkg::OP_NEXT) ? tai_pkg::ST_END : tai_pkg::ST_INVALID;
          state_nxt  = tai_pkg::S_OUT;
        end else begin
          ram_re    = 1'b1;
          state_nxt = tai_pkg::S_EVAL;
        end
      end

      // act on the entry read
      tai_pkg::S_EVAL: begin
        unique case (op_r)
          tai_pkg::OP_NEXT: begin
            i_nxt   = i_r + 1'b1;
            off_nxt = next_off_w;
            if (!ram_rdata.deleted) begin
              ioff_nxt  = off_r;
              enr_nxt   = i_r;
              ilen_nxt  = len_w;
              state_nxt = tai_pkg::S_OUT;
            end else begin
              state_nxt = tai_pkg::S_SCAN;
            end
          end
          tai_pkg::OP_POP: begin
            if (ram_rdata.deleted) begin
              if (first_r) begin
                i_nxt     = i_r + 1'b1;
                state_nxt = tai_pkg::S_SCAN;
              end else begin
                status_nxt = tai_pkg::ST_INVALID;
                state_nxt  = tai_pkg::S_OUT;
              end
            end else begin
              ram_we            = 1'b1;
              ram_wdata.deleted = 1'b1;
              enr_nxt           = i_r;
              live_nxt          = live_r - 1'b1;
              // last live entry gone: empty the arena
              if (live_r == tai_pkg::CNT_W'(1)) begin
                wp_nxt  = '0;
                ew_nxt  = '0;
                ver_nxt = ver_r + 1'b1;
              end
              state_nxt = tai_pkg::S_OUT;
            end
          end
          tai_pkg::OP_CHECK: begin
            if (cver_r == ver_r && !ram_rdata.deleted) begin
              valid_nxt = 1'b1;
              ioff_nxt  = coff_r;
              enr_nxt   = i_r;
              ilen_nxt  = len_w;
            end else begin
              status_nxt = tai_pkg::ST_INVALID;
            end
            state_nxt = tai_pkg::S_OUT;
          end
          tai_pkg::OP_ALLOC: state_nxt = tai_pkg::S_OUT;
        endcase
      end

      // hold the result until its transfer
      tai_pkg::S_OUT: begin
        if (!out_stall) begin
          state_nxt = tai_pkg::S_IDLE;
        end
      end

      default: state_nxt = tai_pkg::S_IDLE;
    endcase
  end

  // handshake
  assign in_stall  = (state_r != tai_pkg::S_IDLE);
  assign out_valid = (state_r == tai_pkg::S_OUT);

  // result fields
  assign out_status          = status_r;
  assign out_item_offset     = ioff_r;
  assign out_entry_number    = enr_r;
  assign out_item_length     = ilen_r;
  assign out_new_next_index  = (op_r == tai_pkg::OP_NEXT) ? i_r : '0;
  assign out_new_next_offset = (op_r == tai_pkg::OP_NEXT) ? off_r : '0;
  assign out_version_out     = (op_r == tai_pkg::OP_NEXT) ? vout_r : ver_r;
  assign out_live_items      = live_r;
  assign out_bytes_used      = wp_r;
  assign out_valid_res       = valid_r;

  // live entries are always a subset of written entries
  a_live_le_written: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= ew_r)
    else $error("live count exceeds written entries");

  // an arena with no live entry is fully reset
  a_empty_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (live_r == '0) |-> (ew_r == '0 && wp_r == '0))
    else $error("empty arena keeps written entries or bytes");

  // write position stays inside the arena
  a_wp_in_arena: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, wp_r} <= (tai_pkg::OFF_W+1)'(tai_pkg::ARENA_BYTES))
    else $error("write position beyond arena");

  // a result transfer frees the block for the next item
  a_out_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !in_stall)
    else $error("block not ready after result transfer");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int MAIN_ITEMS      = 720;
  localparam int TAIL_ITEMS      = 30;
  localparam int WATCHDOG_CYCLES = 10000;

  typedef struct packed {
    tai_pkg::tai_op_t opcode;
    logic [16:0] req_len;
    logic        use_first;
    logic [10:0] cursor_index;
    logic [16:0] cursor_offset;
    logic [10:0] next_index;
    logic [16:0] next_offset;
    logic [31:0] cursor_version;
  } arena_request_t;

  typedef struct packed {
    tai_pkg::tai_status_t status;
    logic [16:0] item_offset;
    logic [10:0] entry_number;
    logic [16:0] item_length;
    logic [10:0] new_next_index;
    logic [16:0] new_next_offset;
    logic [31:0] version_out;
    logic [10:0] live_items;
    logic [16:0] bytes_used;
    logic        valid_res;
  } arena_result_t;

  // shadow copy of the arena index and the results still owed by the block
  class arena_scoreboard;
    logic [tai_pkg::UNITS_W-1:0] units_tab [tai_pkg::MAX_ENTRIES];
    logic [tai_pkg::PAD_W-1:0]   pad_tab [tai_pkg::MAX_ENTRIES];
    bit                 del_tab [tai_pkg::MAX_ENTRIES];
    int unsigned        wpos;
    int unsigned        written;
    int unsigned        live;
    logic [31:0]        version;
    arena_result_t      pending [$];
    int                 errors;

    function new();
      wpos    = 0;
      written = 0;
      live    = 0;
      version = '0;
      errors  = 0;
    endfunction

    function int unsigned entry_len(int unsigned k);
      return units_tab[k] * tai_pkg::ALIGN - pad_tab[k];
    endfunction

    // advance the shadow index by one accepted transfer and queue its result
    function arena_result_t note_request(arena_request_t r);
      arena_result_t e;
      int unsigned   dlen;
      int unsigned   units;
      int unsigned   aligned;
      int unsigned   i;
      int unsigned   off;
      bit            found;
      e = '0;
      e.status = tai_pkg::ST_OK;
      case (r.opcode)
        tai_pkg::OP_ALLOC: begin
          dlen = r.req_len;
          units = (dlen + tai_pkg::ALIGN - 1) / tai_pkg::ALIGN;
          aligned = units * tai_pkg::ALIGN;
          if (written >= tai_pkg::MAX_ENTRIES || wpos + aligned > tai_pkg::ARENA_BYTES) begin
            e.status = tai_pkg::ST_FULL;
          end else begin
            e.item_offset = 17'(wpos);
            e.entry_number = 11'(written);
            units_tab[written] = tai_pkg::UNITS_W'(units);
            pad_tab[written] = tai_pkg::PAD_W'((aligned - dlen) & tai_pkg::PAD_BITS);
            del_tab[written] = 1'b0;
            wpos += aligned;
            written++;
            live++;
          end
        end
        tai_pkg::OP_NEXT: begin
          i = r.next_index;
          off = r.next_offset;
          found = 1'b0;
          // a cursor at its very start picks up the current version
          e.version_out = (r.cursor_index == 0 && r.next_offset == 0) ?
                          version : r.cursor_version;
          e.status = tai_pkg::ST_END;
          while (i < written && !found) begin
            if (!del_tab[i]) begin
              found = 1'b1;
              e.status = tai_pkg::ST_OK;
              e.item_offset = 17'(off);
              e.entry_number = 11'(i);
              e.item_length = 17'(entry_len(i));
            end
            off += units_tab[i] * tai_pkg::ALIGN;
            i++;
          end
          e.new_next_index = 11'(i);
          e.new_next_offset = 17'(off);
        end
        tai_pkg::OP_POP: begin
          if (live == 0) begin
            e.status = tai_pkg::ST_EMPTY;
          end else begin
            i = r.cursor_index;
            if (r.use_first) begin
              i = 0;
              while (i < written && del_tab[i]) i++;
            end
            if (i >= written || del_tab[i]) begin
              e.status = tai_pkg::ST_INVALID;
            end else begin
              del_tab[i] = 1'b1;
              e.entry_number = 11'(i);
              live--;
              // last live entry gone: arena empties, version moves on
              if (live == 0) begin
                wpos = 0;
                written = 0;
                version++;
              end
            end
          end
        end
        tai_pkg::OP_CHECK: begin
          if (r.cursor_version == version && r.cursor_index < written &&
              !del_tab[r.cursor_index]) begin
            e.valid_res = 1'b1;
            e.item_offset = r.cursor_offset;
            e.entry_number = r.cursor_index;
            e.item_length = 17'(entry_len(r.cursor_index));
          end else begin
            e.status = tai_pkg::ST_INVALID;
          end
        end
        default: ;
      endcase
      if (r.opcode != tai_pkg::OP_NEXT) e.version_out = version;
      e.live_items = 11'(live);
      e.bytes_used = 17'(wpos);
      pending.push_back(e);
      return e;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
    endtask

    // compare one result transfer with the oldest owed result
    task check_result(arena_result_t got);
      arena_result_t want;
      if (pending.size() == 0) begin
        report("result with nothing pending", 32'(got.status), 0);
      end else begin
        want = pending.pop_front();
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.item_offset !== want.item_offset)
          report("item_offset", 32'(got.item_offset), 32'(want.item_offset));
        if (got.entry_number !== want.entry_number)
          report("entry_number", 32'(got.entry_number), 32'(want.entry_number));
        if (got.item_length !== want.item_length)
          report("item_length", 32'(got.item_length), 32'(want.item_length));
        if (got.new_next_index !== want.new_next_index)
          report("new_next_index", 32'(got.new_next_index), 32'(want.new_next_index));
        if (got.new_next_offset !== want.new_next_offset)
          report("new_next_offset", 32'(got.new_next_offset), 32'(want.new_next_offset));
        if (got.version_out !== want.version_out)
          report("version_out", got.version_out, want.version_out);
        if (got.live_items !== want.live_items)
          report("live_items", 32'(got.live_items), 32'(want.live_items));
        if (got.bytes_used !== want.bytes_used)
          report("bytes_used", 32'(got.bytes_used), 32'(want.bytes_used));
        if (got.valid_res !== want.valid_res)
          report("valid_res", 32'(got.valid_res), 32'(want.valid_res));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = '0;
  logic [16:0] in_req_len = '0;
  logic        in_use_first = 1'b0;
  logic [10:0] in_cursor_index = '0;
  logic [16:0] in_cursor_offset = '0;
  logic [10:0] in_next_index = '0;
  logic [16:0] in_next_offset = '0;
  logic [31:0] in_cursor_version = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [16:0] out_item_offset;
  logic [10:0] out_entry_number;
  logic [16:0] out_item_length;
  logic [10:0] out_new_next_index;
  logic [16:0] out_new_next_offset;
  logic [31:0] out_version_out;
  logic [10:0] out_live_items;
  logic [16:0] out_bytes_used;
  logic        out_valid_res;

  arena_scoreboard sb;
  arena_result_t   last_expect;
  int              n_sent = 0;
  int              calm_left = 0;
  int              stall_left = 0;
  int              quiet_cycles = 0;
  bit              no_idle = 1'b0;

  // caller-side iteration cursor, fed from the predicted results
  bit              walk_on = 1'b0;
  logic [10:0]     walk_cur;
  logic [10:0]     walk_idx;
  logic [16:0]     walk_off;
  logic [31:0]     walk_ver;

  tombstone_arena_index dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_req_len          (in_req_len),
    .in_use_first        (in_use_first),
    .in_cursor_index     (in_cursor_index),
    .in_cursor_offset    (in_cursor_offset),
    .in_next_index       (in_next_index),
    .in_next_offset      (in_next_offset),
    .in_cursor_version   (in_cursor_version),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_item_offset     (out_item_offset),
    .out_entry_number    (out_entry_number),
    .out_item_length     (out_item_length),
    .out_new_next_index  (out_new_next_index),
    .out_new_next_offset (out_new_next_offset),
    .out_version_out     (out_version_out),
    .out_live_items      (out_live_items),
    .out_bytes_used      (out_bytes_used),
    .out_valid_res       (out_valid_res)
  );

  always #1 clk = ~clk;

  // result side stalls in bursts, with free-running stretches between
  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(1, 14) - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(1, 40) - 1;
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin : result_monitor
    arena_result_t seen;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen.status = tai_pkg::tai_status_t'(out_status);
        seen.item_offset = out_item_offset;
        seen.entry_number = out_entry_number;
        seen.item_length = out_item_length;
        seen.new_next_index = out_new_next_index;
        seen.new_next_offset = out_new_next_offset;
        seen.version_out = out_version_out;
        seen.live_items = out_live_items;
        seen.bytes_used = out_bytes_used;
        seen.valid_res = out_valid_res;
        sb.check_result(seen);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("FAIL tombstone_arena_index");
        $finish;
      end
    end
  end

  function automatic arena_request_t rand_request();
    arena_request_t r;
    r.opcode = tai_pkg::tai_op_t'($urandom_range(0, 3));
    r.req_len = 17'($urandom);
    r.use_first = 1'($urandom);
    r.cursor_index = 11'($urandom);
    r.cursor_offset = 17'($urandom);
    r.next_index = 11'($urandom);
    r.next_offset = 17'($urandom);
    r.cursor_version = $urandom;
    return r;
  endfunction

  // present one request and hold it until the transfer happens
  task automatic send_request(input arena_request_t r);
    in_valid <= 1'b1;
    in_opcode <= r.opcode;
    in_req_len <= r.req_len;
    in_use_first <= r.use_first;
    in_cursor_index <= r.cursor_index;
    in_cursor_offset <= r.cursor_offset;
    in_next_index <= r.next_index;
    in_next_offset <= r.next_offset;
    in_cursor_version <= r.cursor_version;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_expect = sb.note_request(r);
    n_sent++;
  endtask

  // request side gaps in bursts, with calm stretches
  task automatic idle_gap();
    if (!no_idle) begin
      if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 24) == 0) begin
        calm_left = $urandom_range(20, 80);
      end else if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  endtask

  task automatic issue(tai_pkg::tai_op_t op, logic [16:0] dlen, logic first,
                       logic [10:0] cidx, logic [16:0] coff, logic [10:0] nidx,
                       logic [16:0] noff, logic [31:0] cver);
    arena_request_t r;
    r.opcode = op;
    r.req_len = dlen;
    r.use_first = first;
    r.cursor_index = cidx;
    r.cursor_offset = coff;
    r.next_index = nidx;
    r.next_offset = noff;
    r.cursor_version = cver;
    send_request(r);
    idle_gap();
  endtask

  // one iterate with the running cursor; restarts from the top after the end
  task automatic walk_step();
    arena_request_t r;
    r = rand_request();
    r.opcode = tai_pkg::OP_NEXT;
    if (walk_on) begin
      r.cursor_index = walk_cur;
      r.next_index = walk_idx;
      r.next_offset = walk_off;
      r.cursor_version = walk_ver;
    end else begin
      r.cursor_index = '0;
      r.next_index = '0;
      r.next_offset = '0;
    end
    send_request(r);
    if (last_expect.status == tai_pkg::ST_OK) begin
      walk_on = 1'b1;
      walk_cur = last_expect.entry_number;
      walk_idx = last_expect.new_next_index;
      walk_off = last_expect.new_next_offset;
      walk_ver = last_expect.version_out;
    end else begin
      walk_on = 1'b0;
    end
  endtask

  initial begin
    arena_request_t req;
    int             pick;
    int unsigned    room;
    int unsigned    lo;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty arena, small entries, tombstones, full arena, offset wrap
    issue(tai_pkg::OP_POP,   17'd0, 1'b1, 11'd0, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_POP,   17'd0, 1'b0, 11'd5, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_NEXT,  17'd0, 1'b0, 11'd0, 17'd0, 11'd0, 17'd0, 32'hFFFF_FFFF);
    issue(tai_pkg::OP_CHECK, 17'd0, 1'b0, 11'd0, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_ALLOC, 17'd0, 1'b0, 11'd0, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_ALLOC, 17'd1, 1'b0, 11'd0, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_ALLOC, 17'd16, 1'b0, 11'd0, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_ALLOC, 17'd17, 1'b0, 11'd0, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_NEXT,  17'd0, 1'b0, 11'd0, 17'd0, 11'd0, 17'd0, 32'h0000_1234);
    issue(tai_pkg::OP_CHECK, 17'd0, 1'b0, 11'd1, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_CHECK, 17'd0, 1'b0, 11'd1, 17'd0, 11'd0, 17'd0, 32'hFFFF_FFFF);
    issue(tai_pkg::OP_CHECK, 17'd0, 1'b0, 11'h7FF, 17'h1FFFF, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_POP,   17'd0, 1'b0, 11'd1, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_POP,   17'd0, 1'b0, 11'd1, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_POP,   17'd0, 1'b0, 11'h7FF, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_CHECK, 17'd0, 1'b0, 11'd1, 17'd16, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_NEXT,  17'd0, 1'b0, 11'd0, 17'd0, 11'd1, 17'd16, 32'h0000_CAFE);
    issue(tai_pkg::OP_ALLOC, 17'd65536, 1'b0, 11'd0, 17'd0, 11'd0, 17'd0, 32'd0);
    repeat (3) issue(tai_pkg::OP_POP, 17'd0, 1'b1, 11'd0, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_ALLOC, 17'd65536, 1'b0, 11'd0, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_ALLOC, 17'd1, 1'b0, 11'd0, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_ALLOC, 17'd0, 1'b0, 11'd0, 17'd0, 11'd0, 17'd0, 32'd0);
    issue(tai_pkg::OP_NEXT,  17'd0, 1'b0, 11'd5, 17'd0, 11'd0, 17'h1FFFF, 32'h0000_0BAD);
    repeat (2) issue(tai_pkg::OP_POP, 17'd0, 1'b1, 11'd0, 17'd0, 11'd0, 17'd0, 32'd0);

    // random traffic, mostly well-formed cursors and sensible lengths
    while (n_sent < MAIN_ITEMS) begin
      req = rand_request();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        req.opcode = tai_pkg::OP_ALLOC;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: req.req_len = 17'($urandom_range(0, 96));
          7: req.req_len = 17'($urandom_range(0, 4096));
          8: req.req_len = 17'($urandom_range(0, tai_pkg::ARENA_BYTES));
          default: ;
        endcase
        send_request(req);
      end else if (pick < 60) begin
        walk_step();
      end else if (pick < 65) begin
        req.opcode = tai_pkg::OP_NEXT;
        if ($urandom_range(0, 1) == 0) req.next_index = 11'($urandom_range(0, sb.written));
        send_request(req);
      end else if (pick < 80) begin
        req.opcode = tai_pkg::OP_POP;
        if ($urandom_range(0, 9) < 7) req.cursor_index = 11'($urandom_range(0, sb.written));
        send_request(req);
      end else if (pick < 95) begin
        req.opcode = tai_pkg::OP_CHECK;
        if ($urandom_range(0, 9) < 7) begin
          req.cursor_version = sb.version;
          req.cursor_index = 11'($urandom_range(0, sb.written));
        end else if ($urandom_range(0, 1) == 0) begin
          req.cursor_version = sb.version;
        end
        send_request(req);
      end else if (pick < 98) begin
        // empty the arena so the version moves on
        while (sb.live != 0) begin
          req = rand_request();
          req.opcode = tai_pkg::OP_POP;
          req.use_first = ($urandom_range(0, 3) != 0);
          if (!req.use_first) req.cursor_index = 11'($urandom_range(0, sb.written));
          send_request(req);
          idle_gap();
        end
      end else begin
        // full walk from the start to the end of iteration
        walk_on = 1'b0;
        do begin
          walk_step();
          idle_gap();
        end while (walk_on);
      end
      idle_gap();
    end

    // fill the arena up to its byte limit
    while (sb.wpos + tai_pkg::ALIGN <= tai_pkg::ARENA_BYTES &&
           sb.written < tai_pkg::MAX_ENTRIES) begin
      req = rand_request();
      req.opcode = tai_pkg::OP_ALLOC;
      room = tai_pkg::ARENA_BYTES - sb.wpos;
      req.req_len = 17'($urandom_range(room / 2, room));
      send_request(req);
      idle_gap();
    end
    lo = (sb.written > 24) ? sb.written - 24 : 0;

    // last stretch on a full arena, back to back
    no_idle = 1'b1;
    for (int k = 0; k < TAIL_ITEMS; k++) begin
      req = rand_request();
      case (k % 4)
        0: begin
          req.opcode = tai_pkg::OP_ALLOC;
          req.req_len = 17'($urandom_range(0, 64));
        end
        1: begin
          req.opcode = tai_pkg::OP_CHECK;
          req.cursor_index = 11'($urandom_range(lo, sb.written + 6));
          req.cursor_version = sb.version;
        end
        2: begin
          req.opcode = tai_pkg::OP_POP;
          req.cursor_index = 11'($urandom_range(lo, sb.written + 6));
        end
        default: begin
          req.opcode = tai_pkg::OP_NEXT;
          req.next_index = 11'($urandom_range(lo, sb.written));
        end
      endcase
      send_request(req);
    end
    in_valid <= 1'b0;

    // drain outstanding results, then a short settle
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS tombstone_arena_index");
    else
      $display("FAIL tombstone_arena_index");
    $finish;
  end

endmodule
